/* hdl/sider_pkg.sv */
// Shared constants, word types and a clamp helper for the save-image delta run encoder.
package sider_pkg;

    localparam int MAX_FRAME_BYTES = 4096;

    // Store address, frame position (can reach MAX_FRAME_BYTES), run and size counters
    localparam int ADDR_W  = $clog2(MAX_FRAME_BYTES);
    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int RUNS_W  = POS_W;
    localparam int TOTAL_W = $clog2(5 * MAX_FRAME_BYTES + 16);
    localparam int BYTE_W  = 8;

    localparam int HEADER_BYTES      = 4;
    localparam int RECORD_HEAD_BYTES = 8;

    // Largest values of the result fields
    localparam int IndexMax  = 4095;
    localparam int LengthMax = 8191;
    localparam int CountMax  = 4095;
    localparam int SizeMax   = 32767;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [11:0] byte_index;
        logic        byte_changed;
        logic        run_closed;
        logic [11:0] run_offset;
        logic [12:0] run_length;
        logic        frame_done;
        logic        use_delta;
        logic [11:0] run_count;
        logic [14:0] stream_size;
        logic        overflow;
    } result_t;

    // Clamp a value to a field's largest value
    function automatic logic [31:0] sat32(input logic [31:0] v, input logic [31:0] maxv);
        return (v > maxv) ? maxv : v;
    endfunction

endpackage

/* hdl/sider_ram.sv */
// Generic single-write, single-read RAM with registered read data (read returns old data).
module sider_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/save_image_delta_run_encoder_unit.sv */
// Top level of the save-image delta run encoder: compare, run tracking and delta decision.
// An accepted word waits in the input stage until the result register is free or drained.
// Throughput: one word per cycle unless the output stalls; the store read for a byte is
//   issued as the word is accepted, the write-back as it moves to the result register.
// Reset: no previous image, all frame counters cleared; the image store is not
//   cleared, its entries are only used after the frame that wrote them.
module save_image_delta_run_encoder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sider_pkg::item_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sider_pkg::result_t rsp_data
);

    localparam int AW = sider_pkg::ADDR_W;
    localparam int PW = sider_pkg::POS_W;
    localparam int TW = sider_pkg::TOTAL_W;
    localparam int RW = sider_pkg::RUNS_W;

    // ------------------------------------------------------------------
    // Accept side: position of the next incoming byte, drives the store read
    // ------------------------------------------------------------------
    logic [PW-1:0] acc_pos_reg, acc_pos_next;

    // Input stage
    logic              a_valid_reg;
    sider_pkg::item_t  a_item_reg;
    logic [PW-1:0]     a_pos_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_data_reg;

    // Result stage
    logic               o_valid_reg;
    sider_pkg::result_t o_word_reg, o_word_next;

    // Per-frame and image state
    logic          image_valid_reg, image_valid_next;
    logic [PW-1:0] stored_len_reg, stored_len_next;
    logic          in_run_reg, in_run_next;
    logic [AW-1:0] run_begin_reg, run_begin_next;
    logic [RW-1:0] runs_reg, runs_next;
    logic [TW-1:0] total_reg, total_next;
    logic          ovf_reg, ovf_next;

    logic accept;
    logic commit;
    logic [7:0] ram_rdata;

    // Advance the input stage whenever the result register is free or drained
    assign commit    = a_valid_reg && (!o_valid_reg || rsp_ready);
    assign req_ready = !a_valid_reg || commit;
    assign accept    = req_valid && req_ready;

    assign rsp_valid = o_valid_reg;
    assign rsp_data  = o_word_reg;

    // ------------------------------------------------------------------
    // Per-byte logic on the input stage
    // ------------------------------------------------------------------
    logic          in_store;
    logic          have_prev;
    logic [7:0]    prev_byte;
    logic          changed;
    logic          closed_eq;
    logic          closed_last;
    logic          closed;
    logic          in_run_mid;
    logic [AW-1:0] begin_mid;
    logic [PW-1:0] run_end;
    logic [PW-1:0] c_len;
    logic [RW-1:0] runs_mid;
    logic [TW-1:0] total_mid;
    logic [TW-1:0] dsize;
    logic          ovf_now;
    logic [PW:0]   flen;
    logic          delta;
    logic          last;
    logic          fwd_next;

    always_comb
    begin
        last      = a_item_reg.last_byte;
        in_store  = a_pos_reg < PW'(sider_pkg::MAX_FRAME_BYTES);
        have_prev = image_valid_reg && (a_pos_reg < stored_len_reg);
        // Take the byte just written when the read hit the same entry
        prev_byte = fwd_reg ? fwd_data_reg : ram_rdata;
        changed   = in_store && (!have_prev || (prev_byte != a_item_reg.data_byte));

        // An equal byte closes the open run
        closed_eq  = in_store && !changed && in_run_reg;
        in_run_mid = in_store ? changed : in_run_reg;
        begin_mid  = (in_store && changed && !in_run_reg) ? a_pos_reg[AW-1:0] : run_begin_reg;

        // The last byte closes whatever is still open
        closed_last = last && in_run_mid;
        closed      = closed_eq || closed_last;
        run_end     = in_store ? (a_pos_reg + PW'(1)) : PW'(sider_pkg::MAX_FRAME_BYTES);
        c_len       = closed_eq ? (a_pos_reg - PW'(begin_mid)) : (run_end - PW'(begin_mid));

        runs_mid  = runs_reg + RW'(closed);
        total_mid = total_reg
                  + (closed ? (TW'(sider_pkg::RECORD_HEAD_BYTES) + TW'(c_len)) : TW'(0));
        dsize     = total_mid + TW'(sider_pkg::HEADER_BYTES);
        ovf_now   = ovf_reg || !in_store;

        flen  = (PW + 1)'(a_pos_reg) + (PW + 1)'(1);
        delta = last && image_valid_reg && !ovf_now
             && ((PW + 1)'(stored_len_reg) == flen)
             && (32'(dsize) < 32'(flen));

        o_word_next.out_byte     = a_item_reg.data_byte;
        o_word_next.byte_index   = 12'(sider_pkg::sat32(32'(a_pos_reg), sider_pkg::IndexMax));
        o_word_next.byte_changed = changed;
        o_word_next.run_closed   = closed;
        o_word_next.run_offset   = closed
            ? 12'(sider_pkg::sat32(32'(begin_mid), sider_pkg::IndexMax)) : 12'd0;
        o_word_next.run_length   = closed
            ? 13'(sider_pkg::sat32(32'(c_len), sider_pkg::LengthMax)) : 13'd0;
        o_word_next.frame_done   = last;
        o_word_next.use_delta    = delta;
        o_word_next.run_count    = 12'(sider_pkg::sat32(32'(runs_mid), sider_pkg::CountMax));
        o_word_next.stream_size  = 15'(sider_pkg::sat32(32'(dsize), sider_pkg::SizeMax));
        o_word_next.overflow     = ovf_now;

        // Next state: last byte clears the frame, sets the image; else carry the run
        if (last)
        begin
            in_run_next      = 1'b0;
            run_begin_next   = '0;
            runs_next        = '0;
            total_next       = '0;
            ovf_next         = 1'b0;
            image_valid_next = !ovf_now;
            stored_len_next  = ovf_now ? '0 : flen[PW-1:0];
        end
        else
        begin
            in_run_next      = in_run_mid;
            run_begin_next   = begin_mid;
            runs_next        = runs_mid;
            total_next       = total_mid;
            ovf_next         = ovf_now;
            image_valid_next = image_valid_reg;
            stored_len_next  = stored_len_reg;
        end
    end

    // Next accepted position: restart after the last byte, hold at the store end
    always_comb
    begin
        acc_pos_next = acc_pos_reg;
        if (req_data.last_byte)
        begin
            acc_pos_next = '0;
        end
        else if (acc_pos_reg < PW'(sider_pkg::MAX_FRAME_BYTES))
        begin
            acc_pos_next = acc_pos_reg + PW'(1);
        end
    end

    // Read and write of the same entry in one cycle happens after a one-byte frame
    assign fwd_next = commit && in_store
                   && (acc_pos_reg < PW'(sider_pkg::MAX_FRAME_BYTES))
                   && (a_pos_reg[AW-1:0] == acc_pos_reg[AW-1:0]);

    // ------------------------------------------------------------------
    // Previous frame image
    // ------------------------------------------------------------------
    sider_ram #(
        .WIDTH (sider_pkg::BYTE_W),
        .DEPTH (sider_pkg::MAX_FRAME_BYTES)
    ) u_image (
        .clk   (clk),
        .we    (commit && in_store),
        .waddr (a_pos_reg[AW-1:0]),
        .wdata (a_item_reg.data_byte),
        .re    (accept),
        .raddr (acc_pos_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pos_reg     <= '0;
            a_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
            image_valid_reg <= 1'b0;
            stored_len_reg  <= '0;
            in_run_reg      <= 1'b0;
            run_begin_reg   <= '0;
            runs_reg        <= '0;
            total_reg       <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                acc_pos_reg <= acc_pos_next;
            end

            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                a_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                o_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                image_valid_reg <= image_valid_next;
                stored_len_reg  <= stored_len_next;
                in_run_reg      <= in_run_next;
                run_begin_reg   <= run_begin_next;
                runs_reg        <= runs_next;
                total_reg       <= total_next;
                ovf_reg         <= ovf_next;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg   <= req_data;
            a_pos_reg    <= acc_pos_reg;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= a_item_reg.data_byte;
        end
        if (commit)
        begin
            o_word_reg <= o_word_next;
        end
    end

endmodule
